// ----- src/sqseq_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the square-wave sequencer
// no dependencies
package sqseq_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_STOP  = 2'd3;

  localparam int unsigned AddrW     = 10;
  localparam int unsigned DataW     = 8;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned FrameW    = 16;
  localparam int unsigned EnvW      = 9;
  localparam int unsigned PerW      = 11;
  localparam int unsigned DvdW      = 22;
  localparam logic [DvdW-1:0] DIVIDEND = 22'd2400000;
  localparam logic [4:0] DIV_LAST   = 5'd21;
  localparam logic [EnvW-1:0] ENV_RELOAD = 9'd384;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_WRITE, OP_STOP, OP_HDR0, OP_HDR1, OP_HDR2, OP_DIV,
    OP_SCAN_RD, OP_SCAN_CHK, OP_SCAN_Z, OP_PLAY_INIT, OP_TDEC, OP_TCHK,
    OP_TFIRST, OP_TCMD, OP_TFRM, OP_VOICE, OP_ENV, OP_END
  } sqseq_op_e;

  typedef struct packed {
    sqseq_op_e op;
  } sqseq_cmd_t;

  typedef struct packed {
    logic active;
    logic loop;
    logic div_last;
    logic scan_stop;
    logic scan_bzero;
    logic scan_pend;
    logic rd_zero;
    logic fc_in;
    logic t_skip;
    logic t_note;
    logic t_end;
    logic v_done;
  } sqseq_stat_t;

  function automatic logic [11:0] tone_lut(input logic [3:0] n);
    logic [11:0] t;
    case (n)
      4'd0:    t = 12'd2446;
      4'd1:    t = 12'd2309;
      4'd2:    t = 12'd2179;
      4'd3:    t = 12'd2057;
      4'd4:    t = 12'd1942;
      4'd5:    t = 12'd1833;
      4'd6:    t = 12'd1730;
      4'd7:    t = 12'd1633;
      4'd8:    t = 12'd1541;
      4'd9:    t = 12'd1455;
      4'd10:   t = 12'd1373;
      4'd11:   t = 12'd1296;
      default: t = 12'd0;
    endcase
    return t;
  endfunction

endpackage

// ----- src/sqseq_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read RAM with registered read data
// no dependencies
module sqseq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/sqseq_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer controller: steps the datapath through write, start, tick and stop
// depends on sqseq_pkg
module sqseq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          cmd_i,
  input  sqseq_pkg::sqseq_stat_t stat_i,
  output sqseq_pkg::sqseq_cmd_t  ctl_o,
  output logic                busy,
  output logic                valid_o
);
  import sqseq_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_WR     = 5'd1;
  localparam logic [4:0] S_STOP   = 5'd2;
  localparam logic [4:0] S_HDR0   = 5'd3;
  localparam logic [4:0] S_HDR1   = 5'd4;
  localparam logic [4:0] S_HDR2   = 5'd5;
  localparam logic [4:0] S_DIV    = 5'd6;
  localparam logic [4:0] S_SRD    = 5'd7;
  localparam logic [4:0] S_SCHK   = 5'd8;
  localparam logic [4:0] S_SZ     = 5'd9;
  localparam logic [4:0] S_PINIT  = 5'd10;
  localparam logic [4:0] S_TDEC   = 5'd11;
  localparam logic [4:0] S_TCHK   = 5'd12;
  localparam logic [4:0] S_TFIRST = 5'd13;
  localparam logic [4:0] S_TCMD   = 5'd14;
  localparam logic [4:0] S_TFRM   = 5'd15;
  localparam logic [4:0] S_VOICE  = 5'd16;
  localparam logic [4:0] S_ENV    = 5'd17;
  localparam logic [4:0] S_TEND   = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  logic [4:0] state_q, state_d;
  logic       pass_q, pass_d;

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    ctl_o.op = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.op = OP_LATCH;
          pass_d   = 1'b0;
          case (cmd_i)
            CMD_WRITE: state_d = S_WR;
            CMD_START: state_d = S_HDR0;
            CMD_TICK:  state_d = stat_i.active ? S_TDEC : S_DONE;
            default:   state_d = S_STOP;
          endcase
        end
      end
      S_WR: begin
        ctl_o.op = OP_WRITE;
        state_d  = S_DONE;
      end
      S_STOP: begin
        ctl_o.op = OP_STOP;
        state_d  = S_DONE;
      end
      S_HDR0: begin
        ctl_o.op = OP_HDR0;
        state_d  = S_HDR1;
      end
      S_HDR1: begin
        ctl_o.op = OP_HDR1;
        state_d  = S_HDR2;
      end
      S_HDR2: begin
        ctl_o.op = OP_HDR2;
        state_d  = S_DIV;
      end
      S_DIV: begin
        ctl_o.op = OP_DIV;
        if (stat_i.div_last) state_d = S_SRD;
      end
      S_SRD: begin
        if (stat_i.scan_stop) begin
          state_d = S_PINIT;
        end else begin
          ctl_o.op = OP_SCAN_RD;
          state_d  = S_SCHK;
        end
      end
      S_SCHK: begin
        ctl_o.op = OP_SCAN_CHK;
        if (!stat_i.scan_bzero) state_d = S_SRD;
        else if (stat_i.scan_pend) state_d = S_PINIT;
        else state_d = S_SZ;
      end
      S_SZ: begin
        ctl_o.op = OP_SCAN_Z;
        state_d  = stat_i.rd_zero ? S_PINIT : S_SRD;
      end
      S_PINIT: begin
        ctl_o.op = OP_PLAY_INIT;
        state_d  = S_DONE;
      end
      S_TDEC: begin
        ctl_o.op = OP_TDEC;
        state_d  = S_TCHK;
      end
      S_TCHK: begin
        if (stat_i.fc_in) begin
          ctl_o.op = OP_TCHK;
          state_d  = S_TFIRST;
        end else begin
          state_d = S_VOICE;
        end
      end
      S_TFIRST: begin
        ctl_o.op = OP_TFIRST;
        if (stat_i.t_skip || stat_i.t_note) state_d = S_TFRM;
        else if (stat_i.t_end) state_d = S_TEND;
        else state_d = S_TCMD;
      end
      S_TCMD: begin
        ctl_o.op = OP_TCMD;
        if (stat_i.t_note) state_d = S_TFRM;
        else if (stat_i.t_end) state_d = S_TEND;
      end
      S_TFRM: begin
        ctl_o.op = OP_TFRM;
        state_d  = S_VOICE;
      end
      S_VOICE: begin
        if (stat_i.v_done) state_d = S_ENV;
        else ctl_o.op = OP_VOICE;
      end
      S_ENV: begin
        ctl_o.op = OP_ENV;
        state_d  = S_DONE;
      end
      S_TEND: begin
        ctl_o.op = OP_END;
        // a looping score reruns the tick once after the restart
        if (stat_i.loop && !pass_q) begin
          pass_d  = 1'b1;
          state_d = S_TDEC;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = (state_q == S_DONE);

endmodule

// ----- src/sqseq_dp.sv -----
`timescale 1ns / 1ps
// sequencer datapath: score memory, divider, track decoder, voices and mixer
// depends on sqseq_pkg and sqseq_ram
module sqseq_dp #(
  parameter int unsigned SCORE_DEPTH = 1024,
  parameter int unsigned VOICES      = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sqseq_pkg::sqseq_cmd_t        ctl_i,
  input  logic [sqseq_pkg::AddrW-1:0]  addr_i,
  input  logic [sqseq_pkg::DataW-1:0]  data_i,
  output sqseq_pkg::sqseq_stat_t       stat_o,
  output logic [sqseq_pkg::LevelW-1:0] level_o,
  output logic                         playing_o
);
  import sqseq_pkg::*;

  localparam int unsigned PW = $clog2(SCORE_DEPTH);
  localparam int unsigned KW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW = $clog2(VOICES + 1);
  localparam int unsigned DT = 2 * VOICES;

  logic [AddrW-1:0] addr_q;
  logic [DataW-1:0] data_q;
  logic [7:0]       hi_q;
  logic [10:0]      tempo_q;
  logic             loop_q;
  logic [DvdW-1:0]  dvd_q;
  logic [11:0]      rem_q;
  logic [DvdW-1:0]  quo_q;
  logic [4:0]       dcnt_q;
  logic [FrameW-1:0] fl_q, fc_q;
  logic [PW:0]      p_q, guard_q;
  logic [CW-1:0]    tc_q, i_q;
  logic [PW-1:0]    start_q [VOICES];
  logic [PW-1:0]    tpos_q [VOICES];
  logic [PW-1:0]    pos_q;
  logic [4:0]       dt_q [DT];
  logic [4:0]       ticks_q [VOICES];
  logic [4:0]       set_q [VOICES];
  logic [PerW-1:0]  per_q [VOICES];
  logic [PerW-1:0]  ph_q [VOICES];
  logic [7:0]       vol_q [VOICES];
  logic [EnvW-1:0]  env_q;
  logic [LevelW-1:0] sum_q, lvl_q;
  logic             act_q;

  logic [DataW-1:0] b;
  logic [PW-1:0]    raddr;
  logic             we;
  logic [KW-1:0]    k, vidx;
  logic [4:0]       cfg;
  logic [PerW-1:0]  per_v;
  logic [7:0]       vol_v;
  logic [PW-1:0]    pos_nx;
  logic [PW:0]      guard_nx, p_nx;
  logic             gwrap, is_dt, is_set, is_endb;
  logic [2:0]       oct;
  logic [11:0]      tone;
  logic [PerW-1:0]  per_n;
  logic [PerW-1:0]  ph1, ph2, thr;
  logic             sq_hi;
  logic [EnvW-1:0]  envn;
  logic             env_in;
  logic [11:0]      rem_sh;
  logic             ge;
  logic [DvdW-1:0]  quo_n;

  sqseq_ram #(.WIDTH(DataW), .DEPTH(SCORE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (PW'(addr_q)),
    .wdata_i (data_q),
    .raddr_i (raddr),
    .rdata_o (b)
  );

  assign we = (ctl_i.op == OP_WRITE) && (32'(addr_q) < SCORE_DEPTH);

  assign k    = fc_q[KW-1:0];
  assign envn = env_q - 9'd1;
  assign env_in = envn < EnvW'(tc_q);

  always_comb begin
    case (ctl_i.op)
      OP_VOICE: vidx = i_q[KW-1:0];
      OP_ENV:   vidx = envn[KW-1:0];
      default:  vidx = k;
    endcase
  end

  assign cfg   = set_q[vidx];
  assign per_v = per_q[vidx];
  assign vol_v = vol_q[vidx];

  assign pos_nx   = (pos_q == PW'(SCORE_DEPTH - 1)) ? '0 : pos_q + 1'b1;
  assign guard_nx = guard_q + 1'b1;
  assign gwrap    = (guard_nx == (PW+1)'(SCORE_DEPTH));
  assign p_nx     = p_q + 1'b1;
  assign is_dt    = (b[7:6] == 2'b01);
  assign is_set   = (b[7:5] == 3'b001);
  assign is_endb  = (b == 8'h01);

  // note pitch: table entry shifted down by octave
  assign oct   = {1'b0, b[5:4]} + (cfg[3] ? 3'd1 : 3'd4);
  assign tone  = tone_lut(b[3:0]);
  assign per_n = PerW'(tone >> oct);

  assign ph1   = ph_q[vidx] + 1'b1;
  assign ph2   = (ph1 == per_v) ? '0 : ph1;
  assign thr   = per_v >> (cfg[1] ? 2 : 1);
  assign sq_hi = ph2 < thr;

  assign rem_sh = {rem_q[10:0], dvd_q[DvdW-1]};
  assign ge     = rem_sh >= {1'b0, tempo_q};
  assign quo_n  = {quo_q[DvdW-2:0], ge};

  always_comb begin
    case (ctl_i.op)
      OP_HDR1:               raddr = PW'(1);
      OP_SCAN_RD:            raddr = p_q[PW-1:0];
      OP_SCAN_CHK:           raddr = p_nx[PW-1:0];
      OP_TCHK:               raddr = tpos_q[k];
      OP_TFIRST, OP_TCMD:    raddr = pos_nx;
      default:               raddr = '0;
    endcase
  end

  always_comb begin
    stat_o.active     = act_q;
    stat_o.loop       = loop_q;
    stat_o.div_last   = (dcnt_q == DIV_LAST);
    stat_o.scan_stop  = (tc_q == CW'(VOICES)) || (p_q >= (PW+1)'(SCORE_DEPTH));
    stat_o.scan_bzero = (b == '0);
    stat_o.scan_pend  = (p_nx >= (PW+1)'(SCORE_DEPTH));
    stat_o.rd_zero    = (b == '0);
    stat_o.fc_in      = fc_q < FrameW'(tc_q);
    stat_o.t_skip     = (b == '0) || (ticks_q[k] != '0);
    stat_o.t_note     = b[7];
    stat_o.t_end      = !b[7] && (is_endb || gwrap);
    stat_o.v_done     = (i_q == tc_q);
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_LATCH: begin
        addr_q <= addr_i;
        data_q <= data_i;
      end
      OP_HDR1: hi_q <= b;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q <= '0;
      loop_q  <= 1'b0;
      dvd_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      dcnt_q  <= '0;
      fl_q    <= '0;
      fc_q    <= '0;
      p_q     <= '0;
      guard_q <= '0;
      tc_q    <= '0;
      i_q     <= '0;
      pos_q   <= '0;
      env_q   <= 9'd1;
      sum_q   <= '0;
      lvl_q   <= '0;
      act_q   <= 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        start_q[v] <= '0;
        tpos_q[v]  <= '0;
        ticks_q[v] <= '0;
        set_q[v]   <= '0;
        per_q[v]   <= '0;
        ph_q[v]    <= '0;
        vol_q[v]   <= '0;
      end
      for (int d = 0; d < DT; d++) begin
        dt_q[d] <= '0;
      end
    end else begin
      case (ctl_i.op)
        OP_STOP: begin
          act_q <= 1'b0;
          lvl_q <= '0;
        end
        OP_HDR2: begin
          tempo_q <= {hi_q, b[7:5]};
          loop_q  <= b[0];
          dvd_q   <= DIVIDEND;
          rem_q   <= '0;
          quo_q   <= '0;
          dcnt_q  <= '0;
          p_q     <= (PW+1)'(2);
          tc_q    <= '0;
        end
        OP_DIV: begin
          dvd_q  <= dvd_q << 1;
          rem_q  <= ge ? rem_sh - {1'b0, tempo_q} : rem_sh;
          quo_q  <= quo_n;
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DIV_LAST) begin
            // saturate when the quotient overflows the frame counter
            fl_q <= (quo_n[DvdW-1:FrameW] != '0) ? '1 : quo_n[FrameW-1:0];
          end
        end
        OP_SCAN_CHK: p_q <= p_nx;
        OP_SCAN_Z: begin
          if (b != '0) begin
            start_q[tc_q[KW-1:0]] <= p_q[PW-1:0];
            tc_q <= tc_q + 1'b1;
          end
        end
        OP_PLAY_INIT, OP_END: begin
          if (ctl_i.op == OP_END && !loop_q) begin
            act_q <= 1'b0;
            lvl_q <= '0;
          end else begin
            fc_q  <= FrameW'(tc_q);
            env_q <= 9'd1;
            for (int v = 0; v < VOICES; v++) begin
              tpos_q[v]  <= start_q[v];
              ticks_q[v] <= '0;
            end
            if (ctl_i.op == OP_PLAY_INIT) begin
              act_q <= 1'b1;
              lvl_q <= '0;
              for (int v = 0; v < VOICES; v++) begin
                per_q[v] <= '0;
                ph_q[v]  <= '0;
                vol_q[v] <= '0;
              end
            end
          end
        end
        OP_TDEC: begin
          fc_q  <= fc_q - 1'b1;
          i_q   <= '0;
          sum_q <= '0;
        end
        OP_TCHK: begin
          pos_q   <= tpos_q[k];
          guard_q <= '0;
        end
        OP_TFIRST, OP_TCMD: begin
          if (ctl_i.op == OP_TFIRST && b == '0) begin
            // idle track
          end else if (ctl_i.op == OP_TFIRST && ticks_q[k] != '0) begin
            ticks_q[k] <= ticks_q[k] - 1'b1;
          end else if (b[7]) begin
            ticks_q[k] <= dt_q[{k, b[6]}];
            per_q[k]   <= per_n;
            ph_q[k]    <= '0;
            vol_q[k]   <= cfg[2] ? 8'h7f : 8'hff;
            tpos_q[k]  <= pos_nx;
          end else begin
            if (is_dt) dt_q[{k, b[5]}] <= b[4:0];
            else if (is_set) set_q[k] <= b[4:0];
            if (is_endb) begin
              tpos_q[k] <= pos_q;
            end else begin
              pos_q   <= pos_nx;
              guard_q <= guard_nx;
              if (gwrap) tpos_q[k] <= pos_nx;
            end
          end
        end
        OP_TFRM: begin
          if (fc_q == '0) fc_q <= fl_q;
        end
        OP_VOICE: begin
          ph_q[vidx] <= ph2;
          if (sq_hi) sum_q <= sum_q + LevelW'(vol_v >> 2);
          i_q <= i_q + 1'b1;
        end
        OP_ENV: begin
          lvl_q <= sum_q;
          if (env_in) begin
            if (!cfg[0]) vol_q[vidx] <= vol_v - (vol_v >> 4);
            env_q <= (envn == '0) ? ENV_RELOAD : envn;
          end else begin
            env_q <= envn;
          end
        end
        default: ;
      endcase
    end
  end

  assign level_o   = lvl_q;
  assign playing_o = act_q;

endmodule

// ----- src/four_voice_square_wave_sequencer.sv -----
`timescale 1ns / 1ps
// a write or stop passes through one work state before done, and a tick while idle goes straight to done;
// a start reads the header, runs the divider and scans the score, with a zero check on each zero byte
// an active tick decodes track bytes and steps each voice, twice when a looping score restarts
// one command at a time: busy stays high until the valid_o strobe cycle has passed
// reset clears the controller and most datapath state; score memory is undefined until written
// the receiver cannot stall: each result shows for exactly one cycle
module four_voice_square_wave_sequencer #(
  parameter int unsigned SCORE_DEPTH = 1024,
  parameter int unsigned VOICES      = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic [1:0]                   cmd_i,
  input  logic [sqseq_pkg::AddrW-1:0]  addr_i,
  input  logic [sqseq_pkg::DataW-1:0]  data_i,
  output logic                         busy,
  output logic                         valid_o,
  output logic [sqseq_pkg::LevelW-1:0] level_o,
  output logic                         playing_o
);
  import sqseq_pkg::*;

  sqseq_cmd_t  ctl;
  sqseq_stat_t stat;

  sqseq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .cmd_i   (cmd_i),
    .stat_i  (stat),
    .ctl_o   (ctl),
    .busy    (busy),
    .valid_o (valid_o)
  );

  sqseq_dp #(.SCORE_DEPTH(SCORE_DEPTH), .VOICES(VOICES)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .addr_i    (addr_i),
    .data_i    (data_i),
    .stat_o    (stat),
    .level_o   (level_o),
    .playing_o (playing_o)
  );

endmodule

// ----- src/sqseq_chk.sv -----
`timescale 1ns / 1ps
// port-level checks for the square-wave sequencer
// depends on sqseq_pkg, bound to four_voice_square_wave_sequencer
module sqseq_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic [1:0]                   cmd_i,
  input logic [sqseq_pkg::AddrW-1:0]  addr_i,
  input logic [sqseq_pkg::DataW-1:0]  data_i,
  input logic                         busy,
  input logic                         valid_o,
  input logic [sqseq_pkg::LevelW-1:0] level_o,
  input logic                         playing_o
);
  import sqseq_pkg::*;

  // a result transfer only closes an accepted command
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result strobe outside a command");

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(valid_o)) else $error("command ended without result");

  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_STOP) |=> ##1 (valid_o && !playing_o && level_o == '0))
    else $error("stop did not silence the output");

  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !playing_o) |-> (level_o == '0)) else $error("level while idle");

endmodule

bind four_voice_square_wave_sequencer sqseq_chk u_sqseq_chk (.*);
